// File: src/bswv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bowed string voice package
// Sizes, register indexes and the exponential table of the waveguide voice.
// ----------------------------------------------------------------------------
package bswv_pkg;

	localparam int MAX_DELAY = 4096;
	localparam int AW        = $clog2(MAX_DELAY);
	localparam int FW        = AW + 1;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [19:0] DELAY_MIN = 20'd256;
	localparam logic [19:0] DELAY_MAX = 20'(MAX_DELAY * 256 - 1);

	typedef enum logic [2:0] {
		REG_DAMPING  = 3'd0,
		REG_GAIN     = 3'd1,
		REG_MAIN_DLY = 3'd2,
		REG_PICK_DLY = 3'd3,
		REG_FSCALE   = 3'd4,
		REG_FSTEEP   = 3'd5
	} reg_index_t;

	// 2^(-j/16) in Q1.15 for j = 0..16.
	function automatic logic [15:0] pow2_neg(input logic [4:0] j);
		logic [15:0] v;
		case (j)
			5'd0:    v = 16'd32768;
			5'd1:    v = 16'd31379;
			5'd2:    v = 16'd30048;
			5'd3:    v = 16'd28774;
			5'd4:    v = 16'd27554;
			5'd5:    v = 16'd26386;
			5'd6:    v = 16'd25268;
			5'd7:    v = 16'd24196;
			5'd8:    v = 16'd23170;
			5'd9:    v = 16'd22188;
			5'd10:   v = 16'd21247;
			5'd11:   v = 16'd20347;
			5'd12:   v = 16'd19484;
			5'd13:   v = 16'd18658;
			5'd14:   v = 16'd17867;
			5'd15:   v = 16'd17109;
			default: v = 16'd16384;
		endcase
		return v;
	endfunction

	function automatic logic [19:0] clamp_delay(input logic [19:0] d);
		logic [19:0] r;
		r = d;
		if (d < DELAY_MIN) begin
			r = DELAY_MIN;
		end else if (d > DELAY_MAX) begin
			r = DELAY_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/bowed_string_waveguide_voice.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bowed string waveguide voice
// One sample tick per request: two interpolated taps of a shared loop buffer,
// bow friction, tanh bound, damping lowpass and write back into the loop.
// ----------------------------------------------------------------------------
// A request passes the four serial reads of the single memory port, two passes
// through the exponential unit, the restoring divider of the tanh quotient and
// the lowpass; no new request is accepted until its result has left S_OUT.
// Reset: all but the payload registers reset; the loop buffer is not cleared,
// a fill count makes every slot not yet written read as zero.
// ----------------------------------------------------------------------------
module bowed_string_waveguide_voice (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [19:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] bow_velocity,
	input  wire logic [15:0]        bow_pressure,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      sample
);

	localparam int AW = bswv_pkg::AW;
	localparam int FW = bswv_pkg::FW;

	// The sequencer walks one tick through the shared units. The exponential
	// unit is used twice: once for the friction curve, once for tanh.
	typedef enum logic [4:0] {
		S_IDLE, S_RM0, S_RM1, S_RP0, S_RP1, S_RLAST, S_TAP, S_FX,
		S_EXPA, S_EXPB, S_FA, S_FB, S_FC, S_DIVI, S_DIV, S_LP, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] damp_q, gain_q, fscale_q, fsteep_q;
	logic [19:0] mdly_q, pdly_q;

	// Latched request and loop state.
	logic signed [15:0] bv_q;
	logic [15:0]        press_q;
	logic [AW-1:0]      wi_q;
	logic [FW-1:0]      fill_q;
	logic signed [15:0] lps_q;

	// Loop buffer with one registered read port.
	logic signed [15:0] mem [bswv_pkg::MAX_DELAY];
	logic signed [15:0] rdata_q;
	logic               rvalid_q;

	logic signed [15:0] sm0_q, sm1_q, sp0_q, sp1_q;
	logic signed [15:0] vstr_q, pick_q;
	logic [15:0]        av_q;
	logic               vneg_q;

	logic [31:0] exp_in_q;
	logic        tanh_ph_q;
	logic        ysat_q;
	logic [3:0]  yn_q;
	logic [15:0] yt_q;
	logic [15:0] e_q;

	logic [23:0]        a_q, b_q;
	logic signed [18:0] fb_q;
	logic               zneg_q;

	logic [16:0] den_q, rem_q;
	logic [15:0] numsh_q, quo_q;
	logic [3:0]  cnt_q;

	logic               out_valid_q;
	logic signed [16:0] sample_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// Interpolated tap in Q1.15, rounded half up.
	function automatic logic signed [15:0] tap(input logic signed [15:0] s0,
		input logic signed [15:0] s1, input logic [7:0] f);
		logic signed [26:0] a0, a1, w0, w1, acc;
		a0  = 27'(s0);
		a1  = 27'(s1);
		w0  = 27'(9'd256 - {1'b0, f});
		w1  = 27'(f);
		acc = a0 * w0 + a1 * w1 + 27'sd128;
		return 16'(acc >>> 8);
	endfunction

	logic [19:0] mdly_cl, pdly_cl;
	assign mdly_cl = bswv_pkg::clamp_delay(mdly_q);
	assign pdly_cl = bswv_pkg::clamp_delay(pdly_q);

	// Read address: the sample written m ticks ago sits m slots behind the
	// write index. It only counts as written when the fill count covers m.
	logic [FW-1:0] rd_m;
	logic [AW-1:0] rd_addr;
	logic          rd_ok;
	always_comb begin
		case (state_q)
			S_RM1:   rd_m = FW'(mdly_cl[AW+7:8]) + FW'(1);
			S_RP0:   rd_m = FW'(pdly_cl[AW+7:8]);
			S_RP1:   rd_m = FW'(pdly_cl[AW+7:8]) + FW'(1);
			default: rd_m = FW'(mdly_cl[AW+7:8]);
		endcase
		rd_addr = wi_q - rd_m[AW-1:0];
		rd_ok   = (fill_q >= rd_m);
	end

	// Taps and relative velocity.
	logic signed [15:0] vstr_c, pick_c;
	logic signed [16:0] vrel_c;
	always_comb begin
		vstr_c = tap(sm0_q, sm1_q, mdly_cl[7:0]);
		pick_c = tap(sp0_q, sp1_q, pdly_cl[7:0]);
		vrel_c = 17'(bv_q) - 17'(vstr_c);
	end

	// First half of the exponential: scale by log2(e) into Q.16.
	logic [48:0] eprod_c, ysh_c;
	always_comb begin
		eprod_c = 49'(exp_in_q) * 49'(bswv_pkg::LOG2E_Q16);
		ysh_c   = tanh_ph_q ? (eprod_c >> 14) : (eprod_c >> 23);
	end

	// Second half: table interpolation and the shift by the integer part.
	logic [27:0] interp_c;
	logic [15:0] e_c;
	always_comb begin
		interp_c = 28'(bswv_pkg::pow2_neg({1'b0, yt_q[15:12]}))
			* 28'(13'd4096 - {1'b0, yt_q[11:0]})
			+ 28'(bswv_pkg::pow2_neg({1'b0, yt_q[15:12]} + 5'd1)) * 28'(yt_q[11:0])
			+ 28'd2048;
		e_c = ysat_q ? 16'd0 : (interp_c[27:12] >> yn_q);
	end

	// Friction products and the feedback term.
	logic [32:0]        ap_c;
	logic [39:0]        bp_c;
	logic [40:0]        cp_c;
	logic [24:0]        c_c;
	logic signed [32:0] fbp_c;
	logic signed [26:0] z_c;
	logic [25:0]        zmag_c;
	always_comb begin
		ap_c   = 33'(press_q) * 33'(fscale_q) + 33'd128;
		bp_c   = 40'(a_q) * 40'(e_q) + 40'd16384;
		cp_c   = 41'(b_q) * 41'(av_q) + 41'd16384;
		c_c    = cp_c[39:15];
		fbp_c  = 33'(vstr_q) * 33'($signed({1'b0, gain_q})) + 33'sd8192;
		z_c    = 27'(fb_q) + (vneg_q ? -27'($signed({1'b0, c_c}))
			: 27'($signed({1'b0, c_c})));
		zmag_c = z_c[26] ? 26'(-z_c) : 26'(z_c);
	end

	// Divider step: one quotient bit per cycle.
	logic [30:0] dnum_c;
	logic [16:0] dden_c;
	logic [17:0] r2_c;
	logic        ge_c;
	always_comb begin
		dden_c = 17'd32768 + 17'(e_q);
		dnum_c = {16'd32768 - e_q, 15'd0} + 31'(dden_c >> 1);
		r2_c   = {rem_q, numsh_q[15]};
		ge_c   = (r2_c >= {1'b0, den_q});
	end

	// Tanh saturation and the damping lowpass.
	logic [15:0]        dcl_c;
	logic [14:0]        tmag_c;
	logic signed [16:0] u_c;
	logic signed [34:0] lp_c;
	logic signed [15:0] lps_c;
	always_comb begin
		dcl_c  = (damp_q > 16'd32768) ? 16'd32768 : damp_q;
		tmag_c = (quo_q > 16'd32767) ? 15'd32767 : quo_q[14:0];
		u_c    = zneg_q ? -17'($signed({1'b0, tmag_c})) : 17'($signed({1'b0, tmag_c}));
		lp_c   = 35'($signed({1'b0, 17'd32768 - 17'(dcl_c)})) * 35'(u_c)
			+ 35'($signed({1'b0, dcl_c})) * 35'(lps_q) + 35'sd16384;
		lps_c  = 16'(lp_c >>> 15);
	end

	// Loop buffer. Reads of one tick all finish before its write, and the
	// next tick reads only after that write, so no forwarding is needed.
	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (state_q == S_LP) begin
			mem[wi_q] <= lps_c;
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		rvalid_q <= rd_ok;
		case (state_q)
			S_IDLE: begin
				bv_q    <= bow_velocity;
				press_q <= (bow_pressure > 16'd32768) ? 16'd32768 : bow_pressure;
			end
			S_RM1:   sm0_q <= rvalid_q ? rdata_q : 16'sd0;
			S_RP0:   sm1_q <= rvalid_q ? rdata_q : 16'sd0;
			S_RP1:   sp0_q <= rvalid_q ? rdata_q : 16'sd0;
			S_RLAST: sp1_q <= rvalid_q ? rdata_q : 16'sd0;
			S_TAP: begin
				vstr_q <= vstr_c;
				pick_q <= pick_c;
				vneg_q <= vrel_c[16];
				av_q   <= vrel_c[16] ? 16'(-vrel_c) : 16'(vrel_c);
			end
			S_FX: begin
				exp_in_q  <= 32'(fsteep_q) * 32'(av_q);
				tanh_ph_q <= 1'b0;
			end
			S_EXPA: begin
				ysat_q <= |ysh_c[48:20];
				yn_q   <= ysh_c[19:16];
				yt_q   <= ysh_c[15:0];
			end
			S_EXPB: e_q <= e_c;
			S_FA: begin
				a_q  <= ap_c[31:8];
				fb_q <= 19'(fbp_c >>> 14);
			end
			S_FB: b_q <= bp_c[38:15];
			S_FC: begin
				exp_in_q  <= 32'(zmag_c);
				zneg_q    <= z_c[26];
				tanh_ph_q <= 1'b1;
			end
			S_DIVI: begin
				den_q   <= dden_c;
				rem_q   <= 17'(dnum_c[30:16]);
				numsh_q <= dnum_c[15:0];
				quo_q   <= 16'd0;
			end
			S_DIV: begin
				rem_q   <= ge_c ? 17'(r2_c - {1'b0, den_q}) : r2_c[16:0];
				numsh_q <= {numsh_q[14:0], 1'b0};
				quo_q   <= {quo_q[14:0], ge_c};
			end
			default: begin
			end
		endcase
	end

	// Sequencer, configuration, loop state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			damp_q      <= 16'd16384;
			gain_q      <= 16'd16384;
			mdly_q      <= 20'd25600;
			pdly_q      <= 20'd3200;
			fscale_q    <= 16'd256;
			fsteep_q    <= 16'd256;
			wi_q        <= '0;
			fill_q      <= '0;
			lps_q       <= 16'sd0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
			sample_q    <= 17'sd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					bswv_pkg::REG_DAMPING:  damp_q   <= cfg_data[15:0];
					bswv_pkg::REG_GAIN:     gain_q   <= cfg_data[15:0];
					bswv_pkg::REG_MAIN_DLY: mdly_q   <= cfg_data;
					bswv_pkg::REG_PICK_DLY: pdly_q   <= cfg_data;
					bswv_pkg::REG_FSCALE:   fscale_q <= cfg_data[15:0];
					bswv_pkg::REG_FSTEEP:   fsteep_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			// In the output state a new result replaces the one being read.
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_RM0;
				S_RM0:   state_q <= S_RM1;
				S_RM1:   state_q <= S_RP0;
				S_RP0:   state_q <= S_RP1;
				S_RP1:   state_q <= S_RLAST;
				S_RLAST: state_q <= S_TAP;
				S_TAP:   state_q <= S_FX;
				S_FX:    state_q <= S_EXPA;
				S_EXPA:  state_q <= S_EXPB;
				S_EXPB:  state_q <= tanh_ph_q ? S_DIVI : S_FA;
				S_FA:    state_q <= S_FB;
				S_FB:    state_q <= S_FC;
				S_FC:    state_q <= S_EXPA;
				S_DIVI: begin
					cnt_q   <= 4'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_LP;
					end
				end
				S_LP: begin
					lps_q <= lps_c;
					wi_q  <= wi_q + AW'(1);
					if (fill_q != FW'(bswv_pkg::MAX_DELAY)) begin
						fill_q <= fill_q + FW'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold here only while an earlier result is still unread.
					if (!out_valid_q || out_ready) begin
						sample_q    <= 17'(vstr_q) - 17'(pick_q);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: test/tb_bowed_string_waveguide_voice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bowed string waveguide voice testbench
// Sends bow requests through several register settings, predicts every
// output sample with an independent fixed-point model of the waveguide loop
// and compares the samples in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_bowed_string_waveguide_voice;

	// Indexes outside the register map; the block must ignore writes to them.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	// Margin after the last expected sample before the registers change.
	localparam int SETTLE_CYCLES = 48;

	// The scoreboard keeps its own copy of the registers, the loop buffer and
	// the lowpass state, and queues one expected sample per accepted request.
	class bow_scoreboard;
		longint unsigned damping, gain, main_dly, pick_dly, fscale, fsteep;
		logic signed [15:0] loop_mem [bswv_pkg::MAX_DELAY];
		int unsigned wr_ptr;
		longint lp_state;
		logic signed [16:0] expected_q [$];
		int errors;
		longint unsigned pow2_tab [17] = '{32768, 31379, 30048, 28774, 27554,
			26386, 25268, 24196, 23170, 22188, 21247, 20347, 19484, 18658,
			17867, 17109, 16384};

		function new();
			damping  = 16384;
			gain     = 16384;
			main_dly = 25600;
			pick_dly = 3200;
			fscale   = 256;
			fsteep   = 256;
			foreach (loop_mem[i]) loop_mem[i] = '0;
			wr_ptr   = 0;
			lp_state = 0;
			errors   = 0;
		endfunction

		function void write_register(logic [2:0] idx, logic [19:0] data);
			case (idx)
				bswv_pkg::REG_DAMPING:  damping  = data[15:0];
				bswv_pkg::REG_GAIN:     gain     = data[15:0];
				bswv_pkg::REG_MAIN_DLY: main_dly = data;
				bswv_pkg::REG_PICK_DLY: pick_dly = data;
				bswv_pkg::REG_FSCALE:   fscale   = data[15:0];
				bswv_pkg::REG_FSTEEP:   fsteep   = data[15:0];
				default: ;
			endcase
		endfunction

		// Round half up, then floor division by 2^k.
		function longint round_shift(longint x, int k);
			return (x + (longint'(1) <<< (k - 1))) >>> k;
		endfunction

		function longint delayed(longint unsigned m);
			return loop_mem[(wr_ptr + bswv_pkg::MAX_DELAY - m) % bswv_pkg::MAX_DELAY];
		endfunction

		// Linear interpolation between the two samples around a Q.8 delay.
		function longint tap(longint unsigned d);
			longint unsigned dd;
			longint f;
			dd = d;
			if (dd < 256) dd = 256;
			if (dd > bswv_pkg::MAX_DELAY * 256 - 1) dd = bswv_pkg::MAX_DELAY * 256 - 1;
			f = dd & 255;
			return round_shift(delayed(dd >> 8) * (256 - f) + delayed((dd >> 8) + 1) * f, 8);
		endfunction

		// exp(-x) in Q1.15 for x in Q.23, through a 2^(-j/16) table.
		function longint unsigned exp_decay(longint unsigned x);
			longint unsigned y, n, t, j, fr, e;
			y  = (x * 94548) >> 23;
			n  = y >> 16;
			t  = y & 16'hFFFF;
			j  = t >> 12;
			fr = t & 12'hFFF;
			e  = (pow2_tab[j] * (4096 - fr) + pow2_tab[j + 1] * fr + 2048) >> 12;
			if (n >= 16) return 0;
			return e >> n;
		endfunction

		function longint bounded_tanh(longint z);
			longint unsigned mag, e, num, den, t;
			mag = (z < 0) ? -z : z;
			e   = exp_decay(mag << 9);
			num = (32768 - e) * 32768;
			den = 32768 + e;
			t   = (num + den / 2) / den;
			if (t > 32767) t = 32767;
			return (z < 0) ? -longint'(t) : longint'(t);
		endfunction

		function void note_request(logic signed [15:0] bv, logic [15:0] bp);
			longint unsigned p, d, av, e, a, b, c;
			longint vstr, pick, vrel, fric, fb, u;
			p    = (bp > 32768) ? 32768 : bp;
			d    = (damping > 32768) ? 32768 : damping;
			vstr = tap(main_dly);
			pick = tap(pick_dly);
			vrel = longint'(bv) - vstr;
			av   = (vrel < 0) ? -vrel : vrel;
			e    = exp_decay(fsteep * av);
			a    = (p * fscale + 128) >> 8;
			b    = (a * e + 16384) >> 15;
			c    = (b * av + 16384) >> 15;
			fric = (vrel < 0) ? -longint'(c) : longint'(c);
			fb   = round_shift(vstr * longint'(gain), 14);
			u    = bounded_tanh(fb + fric);
			lp_state = round_shift(longint'(32768 - d) * u + longint'(d) * lp_state, 15);
			loop_mem[wr_ptr] = lp_state[15:0];
			wr_ptr = (wr_ptr + 1) % bswv_pkg::MAX_DELAY;
			expected_q.push_back(17'(vstr - pick));
		endfunction

		function void check_sample(logic signed [16:0] got);
			logic signed [16:0] want;
			if (expected_q.size() == 0) begin
				$error("sample: no result expected, actual %0d", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				$error("sample: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [19:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] bow_velocity;
	logic [15:0]        bow_pressure;
	logic               out_valid;
	logic               out_ready;
	logic signed [16:0] sample;

	bow_scoreboard board;
	// Cleared for the final phase, so the last stretch runs without any idling.
	bit idling_on = 1'b1;

	bowed_string_waveguide_voice dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.bow_velocity (bow_velocity),
		.bow_pressure (bow_pressure),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every input is known from time zero. Inputs change only on the falling
	// edge with blocking assignments, so a valid that is dropped and raised again
	// within one step between two back-to-back requests is high at every rising edge.
	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		bow_velocity = '0;
		bow_pressure = '0;
		out_ready    = 1'b0;
	end

	// The result side stalls in random bursts while idling is enabled.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Results are sampled on the rising edge, before the block updates.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) board.check_sample(sample);
		end
	end

	// Waits for every expected sample, then lets the pipeline drain so that
	// nothing is still in flight when the registers change.
	task automatic wait_idle();
		while (board.expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [19:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One request is one audio sample tick of the bowed string.
	task automatic send_request(logic signed [15:0] bv, logic [15:0] bp);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid     = 1'b1;
		bow_velocity = bv;
		bow_pressure = bp;
		do @(posedge clk); while (!in_ready);
		board.note_request(bv, bp);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Random bow requests. Pressure stays mostly in [0, 1] and sometimes goes
	// above one to exercise its saturation.
	task automatic bow_burst(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_request(16'($urandom), 16'($urandom));
			else
				send_request(16'($urandom), 16'($urandom_range(0, 32768)));
		end
	endtask

	task automatic write_all(logic [15:0] damp, logic [15:0] gn, logic [19:0] mdly,
			logic [19:0] pdly, logic [15:0] fs, logic [15:0] fk);
		wait_idle();
		write_register(bswv_pkg::REG_DAMPING, 20'(damp));
		write_register(bswv_pkg::REG_GAIN, 20'(gn));
		write_register(bswv_pkg::REG_MAIN_DLY, mdly);
		write_register(bswv_pkg::REG_PICK_DLY, pdly);
		write_register(bswv_pkg::REG_FSCALE, 20'(fs));
		write_register(bswv_pkg::REG_FSTEEP, 20'(fk));
		// Writes to unmapped indexes must leave every register untouched.
		write_register(REG_SPARE_LO, 20'($urandom));
		write_register(REG_SPARE_HI, 20'($urandom));
	endtask

	initial begin
		board = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed requests at the reset settings: velocity and pressure
		// extremes, pressure above one, and enough ticks for the pickup tap
		// to pick up written samples.
		send_request(16'sh8000, 16'd32768);
		send_request(16'sh7FFF, 16'd32768);
		send_request(16'sh0000, 16'd0);
		send_request(16'sh7FFF, 16'hFFFF);
		send_request(16'sh8000, 16'd32769);
		send_request(16'shFFFF, 16'd1);
		send_request(16'sh0001, 16'h7FFF);
		for (int i = 0; i < 13; i++) send_request(16'sh4000, 16'd24576);

		// Damping and pressure above one, delays below one sample and past
		// the buffer end, maximum gain and scale, no friction decay.
		write_all(16'hFFFF, 16'hFFFF, 20'd0, 20'hFFFFF, 16'hFFFF, 16'd0);
		bow_burst(40);

		// The other extremes: no damping, no feedback, exact delay limits.
		write_all(16'd0, 16'd0, 20'hFFFFF, 20'd256, 16'd0, 16'hFFFF);
		bow_burst(40);

		// A playable string: short delays so the loop fills and circulates.
		write_all(16'd32768, 16'd16000, 20'd2600, 20'd300, 16'd512, 16'd384);
		bow_burst(30);
		// Hold off the sender until every expected sample has come back.
		while (board.expected_q.size() != 0) @(negedge clk);
		bow_burst(30);

		// Random settings, mostly short delays with an occasional full-range one.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) idling_on = 1'b0;
			write_all(16'($urandom), 16'($urandom),
				($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(256, 16384)),
				($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 8192)),
				16'($urandom), 16'($urandom));
			bow_burst(60);
		end

		wait_idle();
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Roughly 700 requests need well under 100 us; this
	// allows for stalls and idling many times over.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
